// ----- design/uhp_pkg.sv -----
// shared types, codes and constants for the unified header parser
package uhp_pkg;

    // parse phase of the current datagram
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_CID     = 3'd1,
        PH_SEQ_HI  = 3'd2,
        PH_SEQ_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_LEN_LO  = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_SKIP    = 3'd7
    } uhp_phase_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_HEADER_OK    = 3'd0,
        ST_CID_BYTE     = 3'd1,
        ST_BAD_PREFIX   = 3'd2,
        ST_TRUNC_HEADER = 3'd3,
        ST_CID_MISMATCH = 3'd4,
        ST_TRUNC_RECORD = 3'd5
    } uhp_status_t;

    // configuration register indexes
    localparam logic CFG_CID_NEGOTIATED = 1'b0;
    localparam logic CFG_CID_BYTES      = 1'b1;

    // first byte layout
    localparam logic [7:0] PREFIX_MASK  = 8'b1110_0000;
    localparam logic [7:0] PREFIX_VALUE = 8'b0010_0000;

    // bit positions inside the stored header flags
    localparam int FLAG_C = 2;
    localparam int FLAG_S = 1;
    localparam int FLAG_L = 0;

    typedef struct packed {
        uhp_phase_t  phase;
        logic [15:0] byte_count;
        logic [2:0]  flags;
        logic [1:0]  epoch;
        logic [15:0] seq;
        logic [15:0] len;
        logic        mismatch;
    } uhp_state_t;

    typedef struct packed {
        uhp_status_t status;
        logic [1:0]  epoch_low;
        logic [15:0] seq_num;
        logic        seq_wide;
        logic        length_present;
        logic [15:0] record_length;
        logic [7:0]  cid_byte;
    } uhp_result_t;

endpackage

// ----- design/dtls_unified_header_parser_unit.sv -----
// top level of the dtls 1.3 unified header parser
// latency: a result request is valid the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; s_tready drops only while a result is held and
//   m_tready is low, the result register decouples the two sides
// reset: rst_n asynchronous active low, clears parse phase, stores, config and out valid
module dtls_unified_header_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // end_of_datagram
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [1:0] epoch_low, [17:2] seq_num, [18] seq_wide,
                                    // [19] length_present, [35:20] record_length,
                                    // [43:36] cid_byte, [47:44] zero
    output logic [2:0]  m_tuser     // [2:0] status
);

    // configuration registers, sampled by the parse step on the first byte
    logic                 cid_negotiated_reg;
    logic [7:0]           cid_bytes_reg;

    // parse state across bytes of one datagram
    uhp_pkg::uhp_state_t  state_reg;
    uhp_pkg::uhp_state_t  state_next;

    uhp_pkg::uhp_result_t step_res;
    logic                 step_res_valid;
    uhp_pkg::uhp_result_t out_data;
    logic                 accept;

    // free when the held result leaves this cycle or nothing is held
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cid_negotiated_reg <= 1'b0;
            cid_bytes_reg      <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uhp_pkg::CFG_CID_NEGOTIATED: cid_negotiated_reg <= cfg_data[0];
                uhp_pkg::CFG_CID_BYTES:      cid_bytes_reg      <= cfg_data;
            endcase
        end
    end

    uhp_step u_step
    (
        .in_last        (s_tlast),
        .in_byte        (s_tdata),
        .cid_negotiated (cid_negotiated_reg),
        .cid_bytes      (cid_bytes_reg),
        .cur            (state_reg),
        .nxt            (state_next),
        .res_valid      (step_res_valid),
        .res            (step_res)
    );

    // state advances only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: uhp_pkg::PH_FIRST, default: '0};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    uhp_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && step_res_valid),
        .load_data (step_res),
        .take      (m_tready),
        .valid     (m_tvalid),
        .data      (out_data)
    );

    assign m_tuser = out_data.status;
    assign m_tdata = {4'd0, out_data.cid_byte, out_data.record_length,
                      out_data.length_present, out_data.seq_wide,
                      out_data.seq_num, out_data.epoch_low};

endmodule

// ----- design/uhp_step.sv -----
// per-byte parse step: next parser state and optional result
module uhp_step
(
    input  logic                 in_last,
    input  logic [7:0]           in_byte,
    input  logic                 cid_negotiated,
    input  logic [7:0]           cid_bytes,
    input  uhp_pkg::uhp_state_t  cur,
    output uhp_pkg::uhp_state_t  nxt,
    output logic                 res_valid,
    output uhp_pkg::uhp_result_t res
);

    logic        prefix_ok;
    logic [15:0] count_dec;
    logic [15:0] seq_cur;
    logic [15:0] len_cur;
    logic        flag_l;
    logic        done_emits;
    logic [15:0] cid_count;

    assign prefix_ok  = (in_byte & uhp_pkg::PREFIX_MASK) == uhp_pkg::PREFIX_VALUE;
    assign count_dec  = cur.byte_count - 16'd1;
    assign flag_l     = cur.flags[uhp_pkg::FLAG_L];
    assign cid_count  = cid_negotiated ? {8'd0, cid_bytes} : 16'd0;
    // low byte of seq / len arrives in the current request on those phases
    assign seq_cur    = (cur.phase == uhp_pkg::PH_SEQ_LO) ? {cur.seq[15:8], in_byte} : cur.seq;
    assign len_cur    = (cur.phase == uhp_pkg::PH_LEN_LO) ? {cur.len[15:8], in_byte} : cur.len;
    // last header byte produces a result unless payload counting starts
    assign done_emits = cur.mismatch || !flag_l || (len_cur == 16'd0) || in_last;

    // next state
    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            uhp_pkg::PH_FIRST:
            begin
                if (!prefix_ok)
                begin
                    nxt.phase = in_last ? uhp_pkg::PH_FIRST : uhp_pkg::PH_SKIP;
                end
                else
                begin
                    nxt.flags    = in_byte[4:2];
                    nxt.epoch    = in_byte[1:0];
                    nxt.seq      = 16'd0;
                    nxt.len      = 16'd0;
                    nxt.mismatch = in_byte[4] != cid_negotiated;
                    if (in_last)
                        nxt.phase = uhp_pkg::PH_FIRST;
                    else
                    begin
                        nxt.byte_count = cid_count;
                        if (cid_count != 16'd0)
                            nxt.phase = uhp_pkg::PH_CID;
                        else
                            nxt.phase = in_byte[3] ? uhp_pkg::PH_SEQ_HI : uhp_pkg::PH_SEQ_LO;
                    end
                end
            end
            uhp_pkg::PH_CID:
            begin
                if (in_last)
                    nxt.phase = uhp_pkg::PH_FIRST;
                else
                begin
                    nxt.byte_count = count_dec;
                    if (count_dec == 16'd0)
                        nxt.phase = cur.flags[uhp_pkg::FLAG_S] ? uhp_pkg::PH_SEQ_HI
                                                               : uhp_pkg::PH_SEQ_LO;
                end
            end
            uhp_pkg::PH_SEQ_HI:
            begin
                if (in_last)
                    nxt.phase = uhp_pkg::PH_FIRST;
                else
                begin
                    nxt.seq   = {in_byte, 8'd0};
                    nxt.phase = uhp_pkg::PH_SEQ_LO;
                end
            end
            uhp_pkg::PH_SEQ_LO:
            begin
                nxt.seq = seq_cur;
                if (flag_l)
                    nxt.phase = in_last ? uhp_pkg::PH_FIRST : uhp_pkg::PH_LEN_HI;
                else
                    nxt.phase = in_last ? uhp_pkg::PH_FIRST : uhp_pkg::PH_SKIP;
            end
            uhp_pkg::PH_LEN_HI:
            begin
                if (in_last)
                    nxt.phase = uhp_pkg::PH_FIRST;
                else
                begin
                    nxt.len   = {in_byte, 8'd0};
                    nxt.phase = uhp_pkg::PH_LEN_LO;
                end
            end
            uhp_pkg::PH_LEN_LO:
            begin
                nxt.len = len_cur;
                if (in_last)
                    nxt.phase = uhp_pkg::PH_FIRST;
                else if (done_emits)
                    nxt.phase = uhp_pkg::PH_SKIP;
                else
                begin
                    nxt.byte_count = len_cur;
                    nxt.phase      = uhp_pkg::PH_PAYLOAD;
                end
            end
            uhp_pkg::PH_PAYLOAD:
            begin
                nxt.byte_count = count_dec;
                if (in_last)
                    nxt.phase = uhp_pkg::PH_FIRST;
                else if (count_dec == 16'd0)
                    nxt.phase = uhp_pkg::PH_SKIP;
            end
            uhp_pkg::PH_SKIP:
            begin
                if (in_last)
                    nxt.phase = uhp_pkg::PH_FIRST;
            end
        endcase
    end

    // result
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        unique case (cur.phase)
            uhp_pkg::PH_FIRST:
            begin
                if (!prefix_ok)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_BAD_PREFIX;
                end
                else if (in_last)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_TRUNC_HEADER;
                end
            end
            uhp_pkg::PH_CID:
            begin
                if (in_last)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_TRUNC_HEADER;
                end
                else if (!cur.mismatch)
                begin
                    res_valid    = 1'b1;
                    res.status   = uhp_pkg::ST_CID_BYTE;
                    res.cid_byte = in_byte;
                end
            end
            uhp_pkg::PH_SEQ_HI, uhp_pkg::PH_LEN_HI:
            begin
                if (in_last)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_TRUNC_HEADER;
                end
            end
            uhp_pkg::PH_SEQ_LO, uhp_pkg::PH_LEN_LO:
            begin
                if ((cur.phase == uhp_pkg::PH_SEQ_LO) && flag_l)
                begin
                    if (in_last)
                    begin
                        res_valid  = 1'b1;
                        res.status = uhp_pkg::ST_TRUNC_HEADER;
                    end
                end
                else if (cur.mismatch)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_CID_MISMATCH;
                end
                else if (!flag_l || (len_cur == 16'd0))
                begin
                    res_valid          = 1'b1;
                    res.status         = uhp_pkg::ST_HEADER_OK;
                    res.epoch_low      = cur.epoch;
                    res.seq_num        = seq_cur;
                    res.seq_wide       = cur.flags[uhp_pkg::FLAG_S];
                    res.length_present = flag_l;
                    res.record_length  = flag_l ? len_cur : 16'd0;
                end
                else if (in_last)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_TRUNC_RECORD;
                end
            end
            uhp_pkg::PH_PAYLOAD:
            begin
                if (count_dec == 16'd0)
                begin
                    res_valid          = 1'b1;
                    res.status         = uhp_pkg::ST_HEADER_OK;
                    res.epoch_low      = cur.epoch;
                    res.seq_num        = seq_cur;
                    res.seq_wide       = cur.flags[uhp_pkg::FLAG_S];
                    res.length_present = flag_l;
                    res.record_length  = flag_l ? len_cur : 16'd0;
                end
                else if (in_last)
                begin
                    res_valid  = 1'b1;
                    res.status = uhp_pkg::ST_TRUNC_RECORD;
                end
            end
            uhp_pkg::PH_SKIP:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/uhp_out_reg.sv -----
// result register with valid flag, holds until the downstream side takes it
module uhp_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  uhp_pkg::uhp_result_t load_data,
    input  logic                 take,
    output logic                 valid,
    output uhp_pkg::uhp_result_t data
);

    logic                 valid_reg;
    logic                 valid_next;
    uhp_pkg::uhp_result_t data_reg;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- design/uhp_checker.sv -----
// port-level checks for the unified header parser, bound to the top level
module uhp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // with no result held the input side is open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result register");

    // only a header result carries header fields
    a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != uhp_pkg::ST_HEADER_OK) |-> m_tdata[35:0] == 36'd0)
        else $error("header fields set on non-header result");

    // only a cid result carries a cid byte
    a_cid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != uhp_pkg::ST_CID_BYTE) |-> m_tdata[47:36] == 12'd0)
        else $error("cid byte set on non-cid result");

    // record length is zero without a length field
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == uhp_pkg::ST_HEADER_OK) && !m_tdata[19]
        |-> m_tdata[35:20] == 16'd0)
        else $error("record length without length flag");

endmodule

bind dtls_unified_header_parser_unit uhp_checker u_uhp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
